>>> rtl/qph_pkg.sv
// ----------------------------------------------------------------------------
// qph_pkg: shared types and constants for the quadratic probe hash table
// Payload structs, result codes and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package qph_pkg;

  localparam int DEF_TABLE_SLOTS = 16;

  localparam int KEY_W        = 31;
  localparam int STATUS_W     = 3;
  localparam int SLOT_FIELD_W = 4;

  // key mod slots by reciprocal multiply, low-bit remainder and one correction
  localparam int RECIP_W   = 32;
  localparam int MOD_STEPS = 3;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_FIELD_W-1:0] slot;
  } out_item_t;

  typedef struct packed {
    logic    clr_we;
    logic    load_in;
    logic    mod_step;
    logic    probe_init;
    logic    rd_en;
    logic    probe_adv;
    logic    ins_we;
    logic    res_load;
    status_t res_status;
    logic    res_use_pos;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic is_search;
    logic slot_valid;
    logic key_match;
    logic probe_last;
  } stat_t;

endpackage

>>> rtl/qph_ctrl.sv
// ----------------------------------------------------------------------------
// qph_ctrl: request sequencer
// Runs the clearing pass, the key reduction, the probe loop and the result
// transfer, and owns both handshakes.
// ----------------------------------------------------------------------------
module qph_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output qph_pkg::cmd_t  cmd,
  input  qph_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SEED,
    S_READ,
    S_CHECK,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.probe_init = 1'b1;
        state_nxt      = S_READ;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_RESP;
        priority if (!stat.slot_valid) begin
          cmd.res_status  = stat.is_search ? qph_pkg::ST_NOT_FOUND : qph_pkg::ST_INSERTED;
          cmd.res_use_pos = !stat.is_search;
          cmd.ins_we      = !stat.is_search;
        end else if (stat.key_match) begin
          cmd.res_status  = stat.is_search ? qph_pkg::ST_FOUND : qph_pkg::ST_PRESENT;
          cmd.res_use_pos = 1'b1;
        end else if (stat.probe_last) begin
          cmd.res_status  = stat.is_search ? qph_pkg::ST_NOT_FOUND : qph_pkg::ST_FULL;
          cmd.res_use_pos = 1'b0;
        end else begin
          cmd.res_load  = 1'b0;
          cmd.probe_adv = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/qph_dp.sv
// ----------------------------------------------------------------------------
// qph_dp: table datapath
// Key store with per-slot valid bit, reciprocal key mod slots reduction,
// incremental quadratic probe position and the result register.
// ----------------------------------------------------------------------------
module qph_dp #(
  parameter int TABLE_SLOTS = qph_pkg::DEF_TABLE_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  qph_pkg::in_item_t  in_data,
  input  qph_pkg::cmd_t      cmd,
  output qph_pkg::stat_t     stat,
  output qph_pkg::out_item_t out_data
);

  localparam int SLOT_W   = $clog2(TABLE_SLOTS);
  localparam int KEY_W    = qph_pkg::KEY_W;
  localparam int RECIP_SH = KEY_W + SLOT_W;
  localparam int PROD_W   = KEY_W + qph_pkg::RECIP_W;
  localparam logic [SLOT_W:0]   SLOTS_X    = (SLOT_W+1)'(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [SLOT_W-1:0] LAST_PROBE = SLOT_W'(TABLE_SLOTS - 2);
  localparam logic [qph_pkg::MOD_CNT_W-1:0] LAST_MOD =
    qph_pkg::MOD_CNT_W'(qph_pkg::MOD_STEPS - 1);
  localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SH) / 64'(TABLE_SLOTS);
  localparam logic [qph_pkg::RECIP_W-1:0] RECIP = RECIP_FULL[qph_pkg::RECIP_W-1:0];

  // valid bit on top of the stored key
  logic [KEY_W:0] mem [TABLE_SLOTS];
  logic [KEY_W:0] rd_data_r;

  logic [KEY_W-1:0]                key_r;
  logic                            search_r;
  logic [PROD_W-1:0]               prod_r;
  logic [SLOT_W:0]                 diff_r, diff_nxt;
  logic [qph_pkg::MOD_CNT_W-1:0]   mod_cnt_r;
  logic [SLOT_W-1:0]               rem_r, rem_nxt;
  logic [SLOT_W-1:0]               pos_r, pos_nxt;
  logic [SLOT_W-1:0]               inc_r, inc_nxt;
  logic [SLOT_W-1:0]               n_r;
  logic [SLOT_W-1:0]               clr_addr_r;
  qph_pkg::status_t                res_status_r;
  logic [qph_pkg::SLOT_FIELD_W-1:0] res_slot_r;
  qph_pkg::out_item_t              out_data_r;

  logic [SLOT_W:0] pos_sum, inc_sum;
  logic [SLOT_W:0] q_lo, qd_lo, diff_fix;

  // quotient estimate is exact or one low, so the remainder is below twice slots
  always_comb begin
    q_lo     = prod_r[RECIP_SH +: (SLOT_W+1)];
    qd_lo    = q_lo * SLOTS_X;
    diff_nxt = key_r[SLOT_W:0] - qd_lo;
    diff_fix = diff_r;
    if (diff_r >= SLOTS_X) diff_fix = diff_r - SLOTS_X;
    rem_nxt  = diff_fix[SLOT_W-1:0];
  end

  // n^2 steps by 2n+1, both kept below slots
  always_comb begin
    pos_sum = {1'b0, pos_r} + {1'b0, inc_r};
    if (pos_sum >= SLOTS_X) pos_sum = pos_sum - SLOTS_X;
    pos_nxt = pos_sum[SLOT_W-1:0];
    inc_sum = {1'b0, inc_r} + (SLOT_W+1)'(2);
    if (inc_sum >= SLOTS_X) inc_sum = inc_sum - SLOTS_X;
    inc_nxt = inc_sum[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_we) begin
      clr_addr_r <= clr_addr_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key_r     <= in_data.key;
      search_r  <= (in_data.req_type == qph_pkg::REQ_SEARCH);
      mod_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      prod_r    <= PROD_W'(key_r) * PROD_W'(RECIP);
      diff_r    <= diff_nxt;
      rem_r     <= rem_nxt;
      mod_cnt_r <= mod_cnt_r + qph_pkg::MOD_CNT_W'(1);
    end
    if (cmd.probe_init) begin
      pos_r <= rem_r;
      inc_r <= SLOT_W'(1);
      n_r   <= '0;
    end else if (cmd.probe_adv) begin
      pos_r <= pos_nxt;
      inc_r <= inc_nxt;
      n_r   <= n_r + SLOT_W'(1);
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_slot_r   <= cmd.res_use_pos ? qph_pkg::SLOT_FIELD_W'(pos_r) : '0;
    end
    if (cmd.out_load) begin
      out_data_r.status <= res_status_r;
      out_data_r.slot   <= res_slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.ins_we) begin
      mem[pos_r] <= {1'b1, key_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data_r <= mem[pos_r];
  end

  assign stat.clr_last   = (clr_addr_r == LAST_SLOT);
  assign stat.mod_last   = (mod_cnt_r == LAST_MOD);
  assign stat.is_search  = search_r;
  assign stat.slot_valid = rd_data_r[KEY_W];
  assign stat.key_match  = (rd_data_r[KEY_W-1:0] == key_r);
  assign stat.probe_last = (n_r == LAST_PROBE);

  assign out_data = out_data_r;

endmodule

>>> rtl/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table: open-addressing key table, quadratic probing
// Insert or search of a 31-bit key; home slot key mod slots, probe n at
// home + n*n mod slots, at most slots - 1 probes.
//
//   channel  ports                        payload
//   input    in_valid / in_stall          in_data  : req_type, key
//   result   out_valid / out_stall        out_data : status, slot
//
// One request at a time: accept, key reduction (reciprocal multiply,
// low-bit remainder, one correction), probe seed, then per probe a
// registered table read and a compare, and last the load of the
// result register; at most TABLE_SLOTS - 1 probes.
// Probes go one by one through the single table read port.
// After reset a clearing pass over every slot runs with in_stall high.
// A new request is taken while a result still waits under out_stall.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table #(
  parameter int TABLE_SLOTS = qph_pkg::DEF_TABLE_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  qph_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output qph_pkg::out_item_t out_data
);

  qph_pkg::cmd_t  cmd;
  qph_pkg::stat_t stat;

  qph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  qph_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for quadratic_probe_hash_table
// Sends insert and search requests through the valid/stall input channel,
// keeps a mirror of the slot table to predict status and slot for every
// accepted request, and compares each result transfer in order. Directed
// requests cover collisions, probe wraparound, a full probe chain and the
// key extremes. Random requests with random sender gaps and receiver
// stalls follow.
// ----------------------------------------------------------------------------
module tb_top;
  import qph_pkg::*;

  localparam int SLOTS        = DEF_TABLE_SLOTS;
  localparam int RANDOM_REQS  = 480;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 80;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  quadratic_probe_hash_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  in_item_t         req_queue[$];
  out_item_t        expected_outcomes[$];
  logic [KEY_W-1:0] used_keys[$];
  logic             tbl_valid[SLOTS];
  logic [KEY_W-1:0] tbl_key[SLOTS];

  out_item_t predicted;
  int        errors;
  int        cycles;
  int        in_gap;
  int        in_calm;
  int        out_wait;
  int        out_calm;
  logic      in_fire;
  logic      out_fire;
  logic      next_valid;

  // insert or search against the mirrored table
  function automatic out_item_t probe_table(in_item_t req);
    out_item_t res;
    int        home;
    int        pos;
    bit        done;
    res.status = (req.req_type == REQ_SEARCH) ? ST_NOT_FOUND : ST_FULL;
    res.slot   = '0;
    home       = int'(req.key % SLOTS);
    done       = 1'b0;
    for (int n = 0; n < SLOTS - 1 && !done; n++) begin
      pos = (home + n * n) % SLOTS;
      if (!tbl_valid[pos]) begin
        if (req.req_type == REQ_INSERT) begin
          tbl_valid[pos] = 1'b1;
          tbl_key[pos]   = req.key;
          res.status     = ST_INSERTED;
          res.slot       = SLOT_FIELD_W'(pos);
        end
        done = 1'b1;
      end else if (tbl_key[pos] == req.key) begin
        res.status = (req.req_type == REQ_SEARCH) ? ST_FOUND : ST_PRESENT;
        res.slot   = SLOT_FIELD_W'(pos);
        done       = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic int draw_idle(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(5, 30);
    return $urandom_range(0, 14);
  endfunction

  task automatic add_req(logic kind, logic [KEY_W-1:0] k);
    in_item_t r;
    r.req_type = kind;
    r.key      = k;
    req_queue.push_back(r);
    used_keys.push_back(k);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      next_valid = in_valid;
      if (in_fire) next_valid = 1'b0;
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (req_queue.size() > 0) begin
          in_data   <= req_queue.pop_front();
          next_valid = 1'b1;
          in_gap     = draw_idle(in_calm);
        end
      end
      in_valid <= next_valid;
    end
  end

  // result receiver stall
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) out_wait = draw_idle(out_calm);
      else if (out_valid && out_wait > 0) out_wait--;
      out_stall <= (out_wait > 0);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          errors++;
          $error("result transfer with no request pending: status %0d slot %0d",
                 out_data.status, out_data.slot);
        end else begin
          predicted = expected_outcomes.pop_front();
          if (out_data.status !== predicted.status) begin
            errors++;
            $error("status: expected %0d, actual %0d", predicted.status, out_data.status);
          end
          if (out_data.slot !== predicted.slot) begin
            errors++;
            $error("slot: expected %0d, actual %0d", predicted.slot, out_data.slot);
          end
        end
      end
      if (in_valid && !in_stall) expected_outcomes.push_back(probe_table(in_data));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[quadratic_probe_hash_table] ERROR");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] k;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    in_fire   = 1'b0;
    out_fire  = 1'b0;
    errors    = 0;
    cycles    = 0;
    in_gap    = 0;
    in_calm   = 0;
    out_wait  = 0;
    out_calm  = 0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    foreach (tbl_key[i]) tbl_key[i] = '0;

    // search on an empty table, then a chain of keys sharing home slot 5
    add_req(REQ_SEARCH, 31'd5);
    add_req(REQ_INSERT, 31'd5);
    add_req(REQ_INSERT, 31'd21);
    add_req(REQ_INSERT, 31'd37);
    add_req(REQ_INSERT, 31'd53);
    // every probed slot taken by other keys
    add_req(REQ_INSERT, 31'd69);
    add_req(REQ_SEARCH, 31'd69);
    add_req(REQ_SEARCH, 31'd5);
    add_req(REQ_SEARCH, 31'd53);
    add_req(REQ_INSERT, 31'd21);
    add_req(REQ_SEARCH, 31'd7);
    // key extremes and wraparound past the last slot
    add_req(REQ_INSERT, 31'd0);
    add_req(REQ_INSERT, 31'h7FFF_FFFF);
    add_req(REQ_SEARCH, 31'h7FFF_FFFF);
    add_req(REQ_INSERT, 31'h7FFF_FFF0);
    add_req(REQ_INSERT, 31'd31);
    add_req(REQ_SEARCH, 31'd31);
    add_req(REQ_SEARCH, 31'h7FFF_FFF0);
    add_req(REQ_SEARCH, 31'h7FFF_FFEF);
    add_req(REQ_INSERT, 31'h4000_0000);
    add_req(REQ_INSERT, 31'h2AAA_AAAA);
    add_req(REQ_SEARCH, 31'h5555_5555);

    repeat (RANDOM_REQS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        4, 5, 6:    k = KEY_W'($urandom);
        default:    k = KEY_W'(($urandom_range(0, 63) << 4) |
                                ($urandom_range(0, 1) ? 2 : 11));
      endcase
      add_req(1'($urandom_range(0, 1)), k);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() > 0 || in_valid || expected_outcomes.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("[quadratic_probe_hash_table] OK");
    end else begin
      $display("[quadratic_probe_hash_table] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/qph_pkg.sv
rtl/qph_ctrl.sv
rtl/qph_dp.sv
rtl/quadratic_probe_hash_table.sv
tb/tb_top.sv
